// ===== hdl/swdm_pkg.sv =====
`timescale 1ns / 1ps

package swdm_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int MIX_BITS      = 32;
  localparam int GAIN_BITS     = 20;
  localparam int DRY_BITS      = 7;
  localparam int RATIO_BITS    = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  // Ratio and gain scaling
  localparam int RATIO_FULL = 127;
  localparam int GAIN_FRAC  = 12;
  localparam int GAIN_ONE   = 4096;
  localparam int DIGIT_BITS = 7;

  // Datapath widths
  localparam int XW    = SAMPLE_BITS + 1;
  localparam int PW    = SAMPLE_BITS + 10;
  localparam int MAGW  = SAMPLE_BITS + 8;
  localparam int PRODW = MAGW + GAIN_BITS;
  localparam int PGW   = PRODW + 1;
  localparam int VW    = PGW - GAIN_FRAC;
  localparam int QW    = VW - 6;
  localparam int BW    = ((MIX_BITS > SAMPLE_BITS) ? MIX_BITS : SAMPLE_BITS) + 3;
  localparam int NW    = ((BW > QW + 1) ? BW : QW + 1) + 1;

  // Number of base-128 digit folds until the remainder is below twice 127
  function automatic int red_steps(input int width);
    int n;
    int s;
    n = width;
    s = 0;
    for (int i = 0; i < 16; i++) begin
      if (n > 13) begin
        n = n - 6;
        s = s + 1;
      end
    end
    return s + 1;
  endfunction

  localparam int NRED = red_steps(VW);

  // Register indexes
  typedef logic [CFG_IDX_BITS-1:0] swdm_cfg_idx_t;
  localparam swdm_cfg_idx_t CFG_MIX_MODE     = 3'd0;
  localparam swdm_cfg_idx_t CFG_DRY_SETTING  = 3'd1;
  localparam swdm_cfg_idx_t CFG_GAIN_Q       = 3'd2;
  localparam swdm_cfg_idx_t CFG_EXPANDED_MIX = 3'd3;
  localparam swdm_cfg_idx_t CFG_ADD_DRY      = 3'd4;
  localparam swdm_cfg_idx_t CFG_INSTRUMENT   = 3'd5;
  localparam swdm_cfg_idx_t CFG_HAS_INPUTS   = 3'd6;

  // Mix mode codes
  typedef logic [2:0] swdm_mode_t;
  localparam swdm_mode_t MODE_NORMAL  = 3'd0;
  localparam swdm_mode_t MODE_WET_SUB = 3'd1;
  localparam swdm_mode_t MODE_DRY_SUB = 3'd2;
  localparam swdm_mode_t MODE_MIX_SUB = 3'd3;
  localparam swdm_mode_t MODE_MID_SUB = 3'd4;
  localparam swdm_mode_t MODE_BALANCE = 3'd5;

  // Channel payloads
  typedef struct packed {
    logic signed [MIX_BITS-1:0]    mix_left;
    logic signed [MIX_BITS-1:0]    mix_right;
    logic signed [SAMPLE_BITS-1:0] wet_left;
    logic signed [SAMPLE_BITS-1:0] wet_right;
    logic signed [SAMPLE_BITS-1:0] dry_left;
    logic signed [SAMPLE_BITS-1:0] dry_right;
    logic                          block_end;
  } swdm_in_t;

  typedef struct packed {
    logic signed [MIX_BITS-1:0] new_mix_left;
    logic signed [MIX_BITS-1:0] new_mix_right;
    logic                       block_end_out;
  } swdm_out_t;

  // Operand select stage, one channel
  typedef struct packed {
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic signed [RATIO_BITS-1:0] ka;
    logic signed [RATIO_BITS-1:0] kb;
    logic                         neg;
    logic signed [BW-1:0]         base;
  } swdm_sel_t;

  typedef struct packed {
    swdm_sel_t [1:0] ch;
    logic            blk;
  } swdm_s1_t;

  // Magnitude stage, one channel
  typedef struct packed {
    logic [MAGW-1:0]      mag;
    logic                 neg;
    logic signed [BW-1:0] base;
  } swdm_mag_t;

  typedef struct packed {
    swdm_mag_t [1:0] ch;
    logic            blk;
  } swdm_s2_t;

  // Gain product stage, one channel
  typedef struct packed {
    logic [PRODW-1:0]     prod;
    logic                 neg;
    logic signed [BW-1:0] base;
  } swdm_prd_t;

  typedef struct packed {
    swdm_prd_t [1:0] ch;
    logic            blk;
  } swdm_s3_t;

  // Divide-by-127 stages, one channel: value = 127 * q + rem
  typedef struct packed {
    logic [QW-1:0]        q;
    logic [VW-1:0]        rem;
    logic                 neg;
    logic signed [BW-1:0] base;
  } swdm_rch_t;

  typedef struct packed {
    swdm_rch_t [1:0] ch;
    logic            blk;
  } swdm_red_t;

  // Pick operands, ratios and the unscaled base term for one channel
  function automatic swdm_sel_t sel_chan(
    input swdm_mode_t                   mode,
    input logic                         add,
    input logic                         is_right,
    input logic signed [RATIO_BITS-1:0] rat_w,
    input logic signed [RATIO_BITS-1:0] rat_r,
    input logic signed [MIX_BITS-1:0]   m_own,
    input logic signed [SAMPLE_BITS-1:0] w_own,
    input logic signed [SAMPLE_BITS-1:0] d_own,
    input logic signed [MIX_BITS-1:0]   m_oth,
    input logic signed [SAMPLE_BITS-1:0] d_oth,
    input logic signed [XW-1:0]         bal_a,
    input logic signed [XW-1:0]         bal_b
  );
    swdm_sel_t            o;
    logic signed [BW-1:0] mb;
    logic signed [BW-1:0] wb;
    logic signed [BW-1:0] db;
    logic signed [BW-1:0] mob;
    logic signed [BW-1:0] dob;
    mb  = BW'(m_own);
    wb  = BW'(w_own);
    db  = BW'(d_own);
    mob = BW'(m_oth);
    dob = BW'(d_oth);
    o.x    = '0;
    o.y    = '0;
    o.ka   = rat_w;
    o.kb   = rat_r;
    o.neg  = 1'b0;
    o.base = mb;
    unique case (mode)
      MODE_NORMAL: begin
        o.x = XW'(w_own);
        o.y = XW'(d_own);
      end
      MODE_WET_SUB: begin
        o.x    = XW'(w_own);
        o.neg  = 1'b1;
        o.base = mb + db;
      end
      MODE_DRY_SUB: begin
        o.x    = XW'(d_own);
        o.ka   = rat_r;
        o.neg  = 1'b1;
        o.base = mb + wb;
      end
      MODE_MIX_SUB: begin
        o.x    = XW'(d_own);
        o.base = mb - wb;
      end
      MODE_MID_SUB: begin
        o.x    = XW'(w_own);
        o.base = -mob - dob;
      end
      MODE_BALANCE: begin
        o.x = bal_a;
        o.y = bal_b;
        if (is_right) begin
          o.ka = rat_r;
          o.kb = rat_w;
        end
      end
      default: begin
      end
    endcase
    if (add) begin
      o.base = o.base + db;
    end
    return o;
  endfunction

  // Form the ratio-weighted sum and split it into sign and magnitude
  function automatic swdm_mag_t mag_chan(input swdm_sel_t s);
    swdm_mag_t            o;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] pm;
    p  = s.x * s.ka + s.y * s.kb;
    pm = p[PW-1] ? -p : p;
    o.mag  = pm[MAGW-1:0];
    o.neg  = p[PW-1] ^ s.neg;
    o.base = s.base;
    return o;
  endfunction

  // Round by adding half the divisor, then strip the power-of-two part
  function automatic swdm_rch_t init_chan(input swdm_prd_t p, input logic half);
    swdm_rch_t      o;
    logic [PGW-1:0] sum;
    sum = {1'b0, p.prod} + (half ? PGW'(RATIO_FULL * GAIN_ONE)
                                 : PGW'(RATIO_FULL * (GAIN_ONE / 2)));
    o.q    = '0;
    o.rem  = half ? VW'(sum >> (GAIN_FRAC + 1)) : VW'(sum >> GAIN_FRAC);
    o.neg  = p.neg;
    o.base = p.base;
    return o;
  endfunction

  // Fold one base-128 digit: 128 * a + b = 127 * a + (a + b)
  function automatic swdm_rch_t red_step(input swdm_rch_t c);
    swdm_rch_t     o;
    logic [VW-1:0] hi;
    hi    = c.rem >> DIGIT_BITS;
    o     = c;
    o.q   = c.q + hi[QW-1:0];
    o.rem = hi + VW'(c.rem[DIGIT_BITS-1:0]);
    return o;
  endfunction

  // Last correction: remainder is below 254, so at most one more 127
  function automatic swdm_rch_t corr_chan(input swdm_rch_t c);
    swdm_rch_t o;
    o   = c;
    o.q = c.q + QW'(c.rem >= VW'(RATIO_FULL));
    return o;
  endfunction

  // Apply sign, add base term and saturate to the mix width
  function automatic logic signed [MIX_BITS-1:0] out_chan(input swdm_rch_t c);
    logic signed [NW-1:0]       qs;
    logic signed [NW-1:0]       n;
    logic [NW-MIX_BITS:0]       top;
    logic signed [MIX_BITS-1:0] r;
    qs  = NW'(c.q);
    n   = NW'(c.base) + (c.neg ? -qs : qs);
    top = n[NW-1:MIX_BITS-1];
    if ((&top) || (~|top)) begin
      r = n[MIX_BITS-1:0];
    end else if (n[NW-1]) begin
      r = {1'b1, {(MIX_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(MIX_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/stereo_wet_dry_mix_modes.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Beat
// in_      in   in_valid/in_stall    swdm_in_t: mix, wet and dry stereo frame
// out_     out  out_valid/out_stall  swdm_out_t: saturated updated mix
// cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// One frame per clock while the output is not stalled. The divide-by-127
// chain folds one 7-bit digit per stage.
// Synchronous reset empties every stage and loads register defaults.
// A stage holds only while the stage after it is full and held; bubbles
// close up, and cfg_ready is always high.

module stereo_wet_dry_mix_modes (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  swdm_pkg::swdm_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output swdm_pkg::swdm_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  swdm_pkg::swdm_cfg_idx_t               cfg_index,
  input  logic [swdm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import swdm_pkg::*;

  localparam int NST     = NRED + 6;
  localparam int ST_S1   = 0;
  localparam int ST_S2   = 1;
  localparam int ST_S3   = 2;
  localparam int ST_RED  = 3;
  localparam int ST_CORR = NRED + 4;
  localparam int ST_OUT  = NRED + 5;

  // Configuration registers
  swdm_mode_t            mix_mode_r;
  logic [DRY_BITS-1:0]   dry_setting_r;
  logic [GAIN_BITS-1:0]  gain_q_r;
  logic                  expanded_mix_r;
  logic                  add_dry_r;
  logic                  instrument_mode_r;
  logic                  has_audio_inputs_r;

  // Derived ratios and mode
  logic [RATIO_BITS:0]          w_exp;
  logic signed [RATIO_BITS-1:0] rat_w;
  logic signed [RATIO_BITS-1:0] rat_r;
  swdm_mode_t                   mode_eff;
  logic                         add_eff;
  logic                         half_eff;
  logic signed [XW-1:0]         bal_a;
  logic signed [XW-1:0]         bal_b;

  // Pipeline control
  logic [NST-1:0] valid_r;
  logic [NST-1:0] valid_nxt;
  logic [NST-1:0] rdy;

  // Pipeline data
  swdm_s1_t  s1_r, s1_nxt;
  swdm_s2_t  s2_r, s2_nxt;
  swdm_s3_t  s3_r, s3_nxt;
  swdm_red_t red_stg_r   [0:NRED];
  swdm_red_t red_stg_nxt [0:NRED];
  swdm_red_t corr_r, corr_nxt;
  swdm_out_t out_r, out_nxt;

  // Take register writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r         <= MODE_NORMAL;
      dry_setting_r      <= '0;
      gain_q_r           <= GAIN_BITS'(GAIN_ONE);
      expanded_mix_r     <= 1'b0;
      add_dry_r          <= 1'b0;
      instrument_mode_r  <= 1'b0;
      has_audio_inputs_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIX_MODE:     mix_mode_r         <= cfg_data[2:0];
        CFG_DRY_SETTING:  dry_setting_r      <= cfg_data[DRY_BITS-1:0];
        CFG_GAIN_Q:       gain_q_r           <= cfg_data[GAIN_BITS-1:0];
        CFG_EXPANDED_MIX: expanded_mix_r     <= cfg_data[0];
        CFG_ADD_DRY:      add_dry_r          <= cfg_data[0];
        CFG_INSTRUMENT:   instrument_mode_r  <= cfg_data[0];
        CFG_HAS_INPUTS:   has_audio_inputs_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Resolve wet/dry ratios, expansion and instrument override
  always_comb begin
    w_exp = {1'b0, dry_setting_r, 1'b0} - (RATIO_BITS+1)'(RATIO_FULL);
    if (has_audio_inputs_r && expanded_mix_r) begin
      rat_w = $signed(w_exp[RATIO_BITS-1:0]);
      rat_r = -rat_w;
    end else begin
      rat_w = $signed({1'b0, dry_setting_r});
      rat_r = instrument_mode_r ? $signed(RATIO_BITS'(RATIO_FULL))
                                : $signed(RATIO_BITS'(RATIO_FULL) - {1'b0, dry_setting_r});
    end
    mode_eff = instrument_mode_r ? MODE_NORMAL : mix_mode_r;
    add_eff  = add_dry_r && !instrument_mode_r;
    half_eff = expanded_mix_r && (mode_eff == MODE_BALANCE);
  end

  // Balance differences
  assign bal_a = XW'(in_data.wet_left) - XW'(in_data.dry_left);
  assign bal_b = XW'(in_data.dry_right) - XW'(in_data.wet_right);

  // Ready chain and valid bits: advance wherever the next stage frees up
  always_comb begin
    rdy[NST-1] = !valid_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NST; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  assign in_stall  = !rdy[ST_S1];
  assign out_valid = valid_r[ST_OUT];
  assign out_data  = out_r;

  // Stage data paths
  always_comb begin
    s1_nxt.blk   = in_data.block_end;
    s1_nxt.ch[0] = sel_chan(mode_eff, add_eff, 1'b0, rat_w, rat_r,
                            in_data.mix_left, in_data.wet_left, in_data.dry_left,
                            in_data.mix_right, in_data.dry_right, bal_a, bal_b);
    s1_nxt.ch[1] = sel_chan(mode_eff, add_eff, 1'b1, rat_w, rat_r,
                            in_data.mix_right, in_data.wet_right, in_data.dry_right,
                            in_data.mix_left, in_data.dry_left, bal_a, bal_b);

    s2_nxt.blk   = s1_r.blk;
    s2_nxt.ch[0] = mag_chan(s1_r.ch[0]);
    s2_nxt.ch[1] = mag_chan(s1_r.ch[1]);

    s3_nxt.blk          = s2_r.blk;
    s3_nxt.ch[0].prod   = s2_r.ch[0].mag * gain_q_r;
    s3_nxt.ch[0].neg    = s2_r.ch[0].neg;
    s3_nxt.ch[0].base   = s2_r.ch[0].base;
    s3_nxt.ch[1].prod   = s2_r.ch[1].mag * gain_q_r;
    s3_nxt.ch[1].neg    = s2_r.ch[1].neg;
    s3_nxt.ch[1].base   = s2_r.ch[1].base;

    red_stg_nxt[0].blk   = s3_r.blk;
    red_stg_nxt[0].ch[0] = init_chan(s3_r.ch[0], half_eff);
    red_stg_nxt[0].ch[1] = init_chan(s3_r.ch[1], half_eff);
    for (int j = 1; j <= NRED; j++) begin
      red_stg_nxt[j].blk   = red_stg_r[j-1].blk;
      red_stg_nxt[j].ch[0] = red_step(red_stg_r[j-1].ch[0]);
      red_stg_nxt[j].ch[1] = red_step(red_stg_r[j-1].ch[1]);
    end

    corr_nxt.blk   = red_stg_r[NRED].blk;
    corr_nxt.ch[0] = corr_chan(red_stg_r[NRED].ch[0]);
    corr_nxt.ch[1] = corr_chan(red_stg_r[NRED].ch[1]);

    out_nxt.block_end_out = corr_r.blk;
    out_nxt.new_mix_left  = out_chan(corr_r.ch[0]);
    out_nxt.new_mix_right = out_chan(corr_r.ch[1]);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload registers: load when the stage advances, hold otherwise
  always_ff @(posedge clk) begin
    if (rdy[ST_S1]) begin
      s1_r <= s1_nxt;
    end
    if (rdy[ST_S2]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[ST_S3]) begin
      s3_r <= s3_nxt;
    end
    for (int j = 0; j <= NRED; j++) begin
      if (rdy[ST_RED + j]) begin
        red_stg_r[j] <= red_stg_nxt[j];
      end
    end
    if (rdy[ST_CORR]) begin
      corr_r <= corr_nxt;
    end
    if (rdy[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== tb/tb_stereo_wet_dry_mix_modes.sv =====
`timescale 1ns / 1ps

module tb_stereo_wet_dry_mix_modes;
  import swdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          TAIL_CYCLES = 40;
  localparam int          NUM_REGS    = 7;

  // Codes outside the defined modes: the mix passes through
  localparam swdm_mode_t MODE_UNDEF_LO = 3'd6;
  localparam swdm_mode_t MODE_UNDEF_HI = 3'd7;

  localparam logic signed [MIX_BITS-1:0]    MIX_MAX  = {1'b0, {(MIX_BITS-1){1'b1}}};
  localparam logic signed [MIX_BITS-1:0]    MIX_MIN  = {1'b1, {(MIX_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0]          GAIN_MAX = '1;

  // Mirror of the mix registers plus the frames still owed by the block
  class mix_scoreboard;
    swdm_mode_t           mode_q;
    logic [DRY_BITS-1:0]  dry_q;
    logic [GAIN_BITS-1:0] gain_q;
    bit                   expand_q;
    bit                   add_dry_q;
    bit                   instr_q;
    bit                   has_in_q;
    swdm_out_t            mix_due[$];
    int unsigned          errors;

    function new();
      mode_q    = MODE_NORMAL;
      dry_q     = '0;
      gain_q    = GAIN_BITS'(GAIN_ONE);
      expand_q  = 1'b0;
      add_dry_q = 1'b0;
      instr_q   = 1'b0;
      has_in_q  = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(swdm_cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_MIX_MODE:     mode_q    = val[2:0];
        CFG_DRY_SETTING:  dry_q     = val[DRY_BITS-1:0];
        CFG_GAIN_Q:       gain_q    = val[GAIN_BITS-1:0];
        CFG_EXPANDED_MIX: expand_q  = val[0];
        CFG_ADD_DRY:      add_dry_q = val[0];
        CFG_INSTRUMENT:   instr_q   = val[0];
        CFG_HAS_INPUTS:   has_in_q  = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return mix_due.size();
    endfunction

    // Round to nearest, ties away from zero
    static function longint round_div(longint n, longint den);
      longint half;
      half = den / 2;
      if (n >= 0) begin
        return (n + half) / den;
      end
      return -((-n + half) / den);
    endfunction

    static function logic signed [MIX_BITS-1:0] clip_mix(longint v);
      longint top;
      top = (longint'(1) <<< (MIX_BITS - 1)) - 1;
      if (v > top) begin
        v = top;
      end else if (v < -top - 1) begin
        v = -top - 1;
      end
      return v[MIX_BITS-1:0];
    endfunction

    // Updated mix for one frame; sums stay exact until the final clip
    function swdm_out_t predict_mix(swdm_in_t f);
      longint     ml, mr, wl, wr, dl, dr;
      longint     w_rat, r_rat, g, den, a, b, nl, nr;
      swdm_mode_t mode;
      swdm_out_t  res;
      ml    = $signed(f.mix_left);
      mr    = $signed(f.mix_right);
      wl    = $signed(f.wet_left);
      wr    = $signed(f.wet_right);
      dl    = $signed(f.dry_left);
      dr    = $signed(f.dry_right);
      w_rat = longint'(dry_q);
      r_rat = instr_q ? longint'(RATIO_FULL) : longint'(RATIO_FULL) - w_rat;
      g     = longint'(gain_q);
      den   = longint'(RATIO_FULL) * GAIN_ONE;
      mode  = instr_q ? MODE_NORMAL : mode_q;
      nl    = ml;
      nr    = mr;
      // Expanded range maps the wet ratio onto -1..1
      if (has_in_q && expand_q) begin
        w_rat = 2 * longint'(dry_q) - RATIO_FULL;
        r_rat = -w_rat;
      end
      case (mode)
        MODE_NORMAL: begin
          nl = ml + round_div((wl * w_rat + dl * r_rat) * g, den);
          nr = mr + round_div((wr * w_rat + dr * r_rat) * g, den);
        end
        MODE_WET_SUB: begin
          nl = ml + dl - round_div(wl * w_rat * g, den);
          nr = mr + dr - round_div(wr * w_rat * g, den);
        end
        MODE_DRY_SUB: begin
          nl = ml + wl - round_div(dl * r_rat * g, den);
          nr = mr + wr - round_div(dr * r_rat * g, den);
        end
        MODE_MIX_SUB: begin
          nl = ml + round_div(dl * w_rat * g, den) - wl;
          nr = mr + round_div(dr * w_rat * g, den) - wr;
        end
        MODE_MID_SUB: begin
          nl = round_div(wl * w_rat * g, den) - mr - dr;
          nr = round_div(wr * w_rat * g, den) - ml - dl;
        end
        MODE_BALANCE: begin
          a = wl - dl;
          b = dr - wr;
          // Halve both ratios whenever expansion is set, inputs or not
          if (expand_q) begin
            den = 2 * den;
          end
          nl = ml + round_div((a * w_rat + b * r_rat) * g, den);
          nr = mr + round_div((a * r_rat + b * w_rat) * g, den);
        end
        default: ;
      endcase
      if (add_dry_q && !instr_q) begin
        nl = nl + dl;
        nr = nr + dr;
      end
      res.new_mix_left  = clip_mix(nl);
      res.new_mix_right = clip_mix(nr);
      res.block_end_out = f.block_end;
      return res;
    endfunction

    function void note_frame(swdm_in_t f);
      mix_due = {mix_due, predict_mix(f)};
    endfunction

    function void note_miss(string field, logic signed [63:0] want,
                            logic signed [63:0] got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_mix(swdm_out_t got);
      swdm_out_t want;
      if (mix_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with no frame pending: %0d %0d %0b", $time,
                 got.new_mix_left, got.new_mix_right, got.block_end_out);
        return;
      end
      want = mix_due.pop_front();
      if (got.new_mix_left !== want.new_mix_left) begin
        note_miss("new_mix_left", want.new_mix_left, got.new_mix_left);
      end
      if (got.new_mix_right !== want.new_mix_right) begin
        note_miss("new_mix_right", want.new_mix_right, got.new_mix_right);
      end
      if (got.block_end_out !== want.block_end_out) begin
        note_miss("block_end_out", 64'(want.block_end_out), 64'(got.block_end_out));
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  swdm_in_t                   in_data;
  logic                       out_valid;
  logic                       out_stall;
  swdm_out_t                  out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  swdm_cfg_idx_t              cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;

  mix_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int            tx_busy_pct = 22;
  int            rx_busy_pct = 35;
  bit            rx_hold_req = 1'b0;

  stereo_wet_dry_mix_modes i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watch all three channels and feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_frame(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_mix(out_data);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_side
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_busy_pct);
    end
  end

  // Offer one frame, idling first at random, and hold it until taken
  task automatic send_frame(input swdm_in_t f);
    if ($urandom_range(0, 99) < tx_busy_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
  endtask

  // Pause the sender until every owed result has come back
  task automatic wait_mix_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all registers back to back; call only while the block is idle
  task automatic apply_setting(input swdm_mode_t mode, input logic [DRY_BITS-1:0] dry,
                               input logic [GAIN_BITS-1:0] gain, input bit expd,
                               input bit add, input bit inst, input bit has);
    logic [CFG_DATA_BITS-1:0] vals [NUM_REGS];
    vals[CFG_MIX_MODE]     = CFG_DATA_BITS'(mode);
    vals[CFG_DRY_SETTING]  = CFG_DATA_BITS'(dry);
    vals[CFG_GAIN_Q]       = CFG_DATA_BITS'(gain);
    vals[CFG_EXPANDED_MIX] = CFG_DATA_BITS'(expd);
    vals[CFG_ADD_DRY]      = CFG_DATA_BITS'(add);
    vals[CFG_INSTRUMENT]   = CFG_DATA_BITS'(inst);
    vals[CFG_HAS_INPUTS]   = CFG_DATA_BITS'(has);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= swdm_cfg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_setting();
    swdm_mode_t           mode;
    logic [DRY_BITS-1:0]  dry;
    logic [GAIN_BITS-1:0] gain;
    if ($urandom_range(0, 9) == 0) begin
      mode = swdm_mode_t'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
    end else begin
      mode = swdm_mode_t'($urandom_range(MODE_BALANCE, MODE_NORMAL));
    end
    case ($urandom_range(0, 3))
      0:       dry = '0;
      1:       dry = '1;
      default: dry = DRY_BITS'($urandom_range(0, RATIO_FULL));
    endcase
    case ($urandom_range(0, 4))
      0:       gain = GAIN_BITS'(GAIN_ONE);
      1:       gain = GAIN_MAX;
      2:       gain = '0;
      3:       gain = GAIN_BITS'($urandom_range(0, 2 * GAIN_ONE));
      default: gain = GAIN_BITS'($urandom());
    endcase
    apply_setting(mode, dry, gain, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0);
  endtask

  // Field value biased toward the extremes and small magnitudes
  function automatic logic [31:0] pick_field(input int bits);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF >> (32 - bits);
      1:       v = ~(32'h7FFF_FFFF >> (32 - bits));
      2:       v = 32'(int'($urandom_range(0, 2048)) - 1024);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic swdm_in_t random_frame();
    swdm_in_t f;
    f.mix_left  = MIX_BITS'(pick_field(MIX_BITS));
    f.mix_right = MIX_BITS'(pick_field(MIX_BITS));
    f.wet_left  = SAMPLE_BITS'(pick_field(SAMPLE_BITS));
    f.wet_right = SAMPLE_BITS'(pick_field(SAMPLE_BITS));
    f.dry_left  = SAMPLE_BITS'(pick_field(SAMPLE_BITS));
    f.dry_right = SAMPLE_BITS'(pick_field(SAMPLE_BITS));
    f.block_end = 1'($urandom_range(0, 1));
    return f;
  endfunction

  // Full-scale frame; flip swaps every sign so both clip limits get hit
  function automatic swdm_in_t extreme_frame(input bit flip);
    swdm_in_t f;
    f.mix_left  = flip ? MIX_MIN : MIX_MAX;
    f.mix_right = flip ? MIX_MAX : MIX_MIN;
    f.wet_left  = flip ? SMP_MIN : SMP_MAX;
    f.wet_right = flip ? SMP_MAX : SMP_MIN;
    f.dry_left  = flip ? SMP_MAX : SMP_MIN;
    f.dry_right = flip ? SMP_MIN : SMP_MAX;
    f.block_end = ~flip;
    return f;
  endfunction

  task automatic send_extremes();
    send_frame(extreme_frame(1'b0));
    send_frame(extreme_frame(1'b1));
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIX_MODE;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, then each mode and the corner settings
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_WET_SUB, 7'd127, GAIN_MAX, 1'b0, 1'b1, 1'b0, 1'b1);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_DRY_SUB, 7'd64, GAIN_BITS'(GAIN_ONE), 1'b1, 1'b0, 1'b0, 1'b1);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_MIX_SUB, 7'd127, GAIN_MAX, 1'b1, 1'b1, 1'b0, 1'b1);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_MID_SUB, 7'd0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_MID_SUB, 7'd127, GAIN_MAX, 1'b1, 1'b1, 1'b0, 1'b1);
    send_extremes();
    // Balance halving applies even without audio inputs
    wait_mix_drained();
    apply_setting(MODE_BALANCE, 7'd100, GAIN_MAX, 1'b1, 1'b0, 1'b0, 1'b0);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_BALANCE, 7'd0, GAIN_BITS'(GAIN_ONE), 1'b1, 1'b1, 1'b0, 1'b1);
    send_extremes();
    // Undefined modes pass the mix through, added dry still applies
    wait_mix_drained();
    apply_setting(MODE_UNDEF_LO, 7'd50, GAIN_BITS'(GAIN_ONE), 1'b0, 1'b1, 1'b0, 1'b1);
    send_extremes();
    // Instrument forces normal mode and drops the added dry
    wait_mix_drained();
    apply_setting(MODE_UNDEF_HI, 7'd3, GAIN_MAX, 1'b1, 1'b1, 1'b1, 1'b1);
    send_extremes();
    wait_mix_drained();
    apply_setting(MODE_NORMAL, 7'd127, GAIN_BITS'(1), 1'b0, 1'b1, 1'b1, 1'b0);
    send_extremes();

    // Random phases, each under a fresh setting
    for (int p = 0; p < 10; p++) begin
      wait_mix_drained();
      apply_random_setting();
      tx_busy_pct = (p == 3) ? 0 : 22;
      rx_busy_pct = (p == 3) ? 0 : 35;
      // Hold off the result side while frames keep coming
      if (p == 6) begin
        tx_busy_pct = 0;
        rx_hold_req = 1'b1;
      end
      repeat ((p == 3) ? 80 : 36) send_frame(random_frame());
    end

    wait_mix_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
